>>> design/terminal_escape_key_decoder_defines.svh
// Assertion macros used by the checker file.
`ifndef TERMINAL_ESCAPE_KEY_DECODER_DEFINES_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TEKD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tekd check failed");

// Next-cycle implication, disabled while reset is held.
`define TEKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tekd check failed");

`endif

>>> design/tekd_pkg.sv
`timescale 1ns / 1ps

package tekd_pkg;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_ESC   = 4'd1,
        PH_CSI   = 4'd2,
        PH_SS3   = 4'd3,
        PH_OTHER = 4'd4,
        PH_DIGIT = 4'd5,
        PH_ONE   = 4'd6,
        PH_SEMI  = 4'd7,
        PH_FIVE  = 4'd8
    } t_phase;

    typedef enum logic [3:0] {
        K_PLAIN  = 4'd0,
        K_ESC    = 4'd1,
        K_UP     = 4'd2,
        K_DOWN   = 4'd3,
        K_RIGHT  = 4'd4,
        K_LEFT   = 4'd5,
        K_CUP    = 4'd6,
        K_CDOWN  = 4'd7,
        K_CRIGHT = 4'd8,
        K_CLEFT  = 4'd9,
        K_HOME   = 4'd10,
        K_END    = 4'd11,
        K_DEL    = 4'd12,
        K_PGUP   = 4'd13,
        K_PGDN   = 4'd14
    } t_key;

    localparam logic [7:0] BYTE_ESC    = 8'd27;
    localparam logic [7:0] BYTE_LBRACK = 8'h5B;  // '['
    localparam logic [7:0] BYTE_O      = 8'h4F;  // 'O'
    localparam logic [7:0] BYTE_ONE    = 8'd49;  // '1'
    localparam logic [7:0] BYTE_SEMI   = 8'd59;  // ';'
    localparam logic [7:0] BYTE_FIVE   = 8'd53;  // '5'
    localparam logic [7:0] BYTE_TILDE  = 8'h7E;  // '~'
    localparam logic [7:0] BYTE_D0     = 8'h30;  // '0'
    localparam logic [7:0] BYTE_D3     = 8'h33;
    localparam logic [7:0] BYTE_D5     = 8'h35;
    localparam logic [7:0] BYTE_D6     = 8'h36;
    localparam logic [7:0] BYTE_D9     = 8'h39;
    localparam logic [7:0] BYTE_H      = 8'h48;
    localparam logic [7:0] BYTE_F      = 8'h46;
    localparam logic [7:0] BYTE_A      = 8'h41;
    localparam logic [7:0] BYTE_B      = 8'h42;
    localparam logic [7:0] BYTE_C      = 8'h43;
    localparam logic [7:0] BYTE_D      = 8'h44;

    localparam int unsigned KEY_W  = 4;
    localparam int unsigned BYTE_W = 8;

    // Arrow final byte to key; K_PLAIN when not an arrow.
    function automatic t_key arrow_of(input logic [7:0] b);
        t_key k;
        unique case (b)
            BYTE_A:  k = K_UP;
            BYTE_B:  k = K_DOWN;
            BYTE_C:  k = K_RIGHT;
            BYTE_D:  k = K_LEFT;
            default: k = K_PLAIN;
        endcase
        return k;
    endfunction

    function automatic t_key ctrl_arrow_of(input logic [7:0] b);
        t_key k;
        unique case (b)
            BYTE_A:  k = K_CUP;
            BYTE_B:  k = K_CDOWN;
            BYTE_C:  k = K_CRIGHT;
            BYTE_D:  k = K_CLEFT;
            default: k = K_PLAIN;
        endcase
        return k;
    endfunction

endpackage

>>> design/terminal_escape_key_decoder.sv
`timescale 1ns / 1ps

// Decodes a terminal byte stream (or read-timeout ticks, i_mode = 1) into key
// codes: plain bytes pass through with key code 0, VT100 cursor, home/end,
// delete, page and ctrl-arrow sequences map to their codes, a timeout inside a
// short sequence gives a lone ESC, and broken sequences are dropped. One word
// is taken every cycle while o_in_stall is low; a word goes through the input
// register and one pass of the phase decoder into the result register, which
// drives the key outputs. Words that finish nothing produce no output word.
// Output stall backs up through the single input register to o_in_stall.
module terminal_escape_key_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [tekd_pkg::BYTE_W-1:0]     i_data_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [tekd_pkg::KEY_W-1:0]      o_key_code,
    output logic [tekd_pkg::BYTE_W-1:0]     o_char_value
);

    logic                         r_in_valid;
    logic                         r_in_mode;
    logic [tekd_pkg::BYTE_W-1:0]  r_in_byte;

    tekd_pkg::t_phase             r_phase;
    tekd_pkg::t_phase             n_phase;
    logic [tekd_pkg::BYTE_W-1:0]  r_digit;
    logic [tekd_pkg::BYTE_W-1:0]  n_digit;

    logic                         r_out_valid;
    tekd_pkg::t_key               r_key;
    logic [tekd_pkg::BYTE_W-1:0]  r_char;

    logic                         res_valid;
    tekd_pkg::t_key               res_key;
    logic [tekd_pkg::BYTE_W-1:0]  res_char;
    tekd_pkg::t_key               arrow_k;
    tekd_pkg::t_key               carrow_k;

    logic out_free;
    logic proc_go;
    logic in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc_go    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign arrow_k  = tekd_pkg::arrow_of(r_in_byte);
    assign carrow_k = tekd_pkg::ctrl_arrow_of(r_in_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_mode <= i_mode;
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tekd_pkg::PH_IDLE;
            r_digit <= '0;
        end else if (proc_go) begin
            r_phase <= n_phase;
            r_digit <= n_digit;
        end
    end

    // Phase decoder: one word per pass.
    always_comb begin
        n_phase   = r_phase;
        n_digit   = r_digit;
        res_valid = 1'b0;
        res_key   = tekd_pkg::K_PLAIN;
        res_char  = '0;

        unique case (r_phase)
            tekd_pkg::PH_ESC, tekd_pkg::PH_CSI, tekd_pkg::PH_SS3, tekd_pkg::PH_OTHER,
            tekd_pkg::PH_DIGIT, tekd_pkg::PH_ONE, tekd_pkg::PH_SEMI,
            tekd_pkg::PH_FIVE: begin
                // broken sequence unless an arm below says otherwise
                n_phase = tekd_pkg::PH_ESC;
                if (r_in_mode) begin
                    if (r_phase == tekd_pkg::PH_ONE || r_phase == tekd_pkg::PH_SEMI ||
                        r_phase == tekd_pkg::PH_FIVE) begin
                        n_phase = tekd_pkg::PH_ESC;
                    end else begin
                        n_phase   = tekd_pkg::PH_IDLE;
                        res_valid = 1'b1;
                        res_key   = tekd_pkg::K_ESC;
                    end
                end else begin
                    case (r_phase)
                        tekd_pkg::PH_ESC: begin
                            if (r_in_byte == tekd_pkg::BYTE_LBRACK) begin
                                n_phase = tekd_pkg::PH_CSI;
                            end else if (r_in_byte == tekd_pkg::BYTE_O) begin
                                n_phase = tekd_pkg::PH_SS3;
                            end else begin
                                n_phase = tekd_pkg::PH_OTHER;
                            end
                        end
                        tekd_pkg::PH_CSI: begin
                            if (r_in_byte == tekd_pkg::BYTE_ONE) begin
                                n_phase = tekd_pkg::PH_ONE;
                            end else if (r_in_byte >= tekd_pkg::BYTE_D0 &&
                                         r_in_byte <= tekd_pkg::BYTE_D9) begin
                                n_phase = tekd_pkg::PH_DIGIT;
                                n_digit = r_in_byte;
                            end else if (arrow_k != tekd_pkg::K_PLAIN) begin
                                n_phase   = tekd_pkg::PH_IDLE;
                                res_valid = 1'b1;
                                res_key   = arrow_k;
                            end else if (r_in_byte == tekd_pkg::BYTE_H) begin
                                n_phase   = tekd_pkg::PH_IDLE;
                                res_valid = 1'b1;
                                res_key   = tekd_pkg::K_HOME;
                            end else if (r_in_byte == tekd_pkg::BYTE_F) begin
                                n_phase   = tekd_pkg::PH_IDLE;
                                res_valid = 1'b1;
                                res_key   = tekd_pkg::K_END;
                            end
                        end
                        tekd_pkg::PH_SS3: begin
                            if (r_in_byte == tekd_pkg::BYTE_H) begin
                                n_phase   = tekd_pkg::PH_IDLE;
                                res_valid = 1'b1;
                                res_key   = tekd_pkg::K_HOME;
                            end else if (r_in_byte == tekd_pkg::BYTE_F) begin
                                n_phase   = tekd_pkg::PH_IDLE;
                                res_valid = 1'b1;
                                res_key   = tekd_pkg::K_END;
                            end
                        end
                        tekd_pkg::PH_DIGIT: begin
                            if (r_in_byte == tekd_pkg::BYTE_TILDE) begin
                                if (r_digit == tekd_pkg::BYTE_D3) begin
                                    n_phase   = tekd_pkg::PH_IDLE;
                                    res_valid = 1'b1;
                                    res_key   = tekd_pkg::K_DEL;
                                end else if (r_digit == tekd_pkg::BYTE_D5) begin
                                    n_phase   = tekd_pkg::PH_IDLE;
                                    res_valid = 1'b1;
                                    res_key   = tekd_pkg::K_PGUP;
                                end else if (r_digit == tekd_pkg::BYTE_D6) begin
                                    n_phase   = tekd_pkg::PH_IDLE;
                                    res_valid = 1'b1;
                                    res_key   = tekd_pkg::K_PGDN;
                                end
                            end
                        end
                        tekd_pkg::PH_ONE: begin
                            if (r_in_byte == tekd_pkg::BYTE_SEMI) begin
                                n_phase = tekd_pkg::PH_SEMI;
                            end
                        end
                        tekd_pkg::PH_SEMI: begin
                            if (r_in_byte == tekd_pkg::BYTE_FIVE) begin
                                n_phase = tekd_pkg::PH_FIVE;
                            end
                        end
                        tekd_pkg::PH_FIVE: begin
                            if (carrow_k != tekd_pkg::K_PLAIN) begin
                                n_phase   = tekd_pkg::PH_IDLE;
                                res_valid = 1'b1;
                                res_key   = carrow_k;
                            end
                        end
                        default: begin
                            // after ESC and another byte: that byte is dropped
                            n_phase = tekd_pkg::PH_ESC;
                        end
                    endcase
                end
            end
            default: begin
                // idle, and any unused code behaves as idle
                n_phase = tekd_pkg::PH_IDLE;
                if (!r_in_mode) begin
                    if (r_in_byte == tekd_pkg::BYTE_ESC) begin
                        n_phase = tekd_pkg::PH_ESC;
                    end else begin
                        res_valid = 1'b1;
                        res_key   = tekd_pkg::K_PLAIN;
                        res_char  = r_in_byte;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (proc_go && res_valid) begin
            r_key  <= res_key;
            r_char <= res_char;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_key_code   = r_key;
    assign o_char_value = r_char;

endmodule

>>> design/tekd_checker.sv
`timescale 1ns / 1ps

`include "terminal_escape_key_decoder_defines.svh"

module tekd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [tekd_pkg::KEY_W-1:0]  o_key_code,
    input logic [tekd_pkg::BYTE_W-1:0] o_char_value
);

    // only plain keys carry a byte
    `TEKD_ASSERT_NOW(a_char_only_plain, i_clk, i_rst_n, o_out_valid && o_key_code != tekd_pkg::K_PLAIN, o_char_value == '0)

    // ESC never leaks out as a plain byte
    `TEKD_ASSERT_NOW(a_no_plain_esc, i_clk, i_rst_n, o_out_valid && o_key_code == tekd_pkg::K_PLAIN, o_char_value != tekd_pkg::BYTE_ESC)

    `TEKD_ASSERT_NOW(a_key_range, i_clk, i_rst_n, o_out_valid, o_key_code <= tekd_pkg::K_PGDN)

    `TEKD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_key_code) && $stable(o_char_value))

endmodule

bind terminal_escape_key_decoder tekd_checker u_tekd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_key_code   (o_key_code),
    .o_char_value (o_char_value)
);

>>> verif/terminal_escape_key_decoder_tb.sv
`timescale 1ns / 1ps

module terminal_escape_key_decoder_tb;

    localparam int N_WORDS     = 1500;
    localparam int TAIL_WORDS  = 150;
    localparam int HOLD_CYCLES = 40;
    localparam int HOLD_AFTER  = 200;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        bit         tick;
        logic [7:0] data;
    } t_in_word;

    typedef struct {
        tekd_pkg::t_key key;
        logic [7:0]     ch;
    } t_key_word;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          i_mode = 1'b0;
    logic [tekd_pkg::BYTE_W-1:0]   i_data_byte = '0;
    logic                          i_out_stall = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [tekd_pkg::KEY_W-1:0]    o_key_code;
    logic [tekd_pkg::BYTE_W-1:0]   o_char_value;

    t_in_word  pend_q[$];
    t_key_word key_exp_q[$];

    // decoder state as predicted
    tekd_pkg::t_phase dec_phase = tekd_pkg::PH_IDLE;
    logic [7:0]       dec_digit = 8'h00;

    int errors = 0;
    int keys_seen = 0;
    int cycles = 0;
    int in_gap = 0;
    int out_gap = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;

    terminal_escape_key_decoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_key_code   (o_key_code),
        .o_char_value (o_char_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Idle bursts only outside the tail, and not in every stretch of the run.
    function automatic bit idle_allowed();
        return pend_q.size() >= TAIL_WORDS && ((pend_q.size() / 128) % 3) != 0;
    endfunction

    function automatic void decode_word(input bit tick, input logic [7:0] b);
        tekd_pkg::t_phase nxt;
        tekd_pkg::t_key   k;
        logic [7:0]       c;
        bit               emit;
        nxt  = tekd_pkg::PH_ESC;  // broken sequence: drop, wait as after ESC
        k    = tekd_pkg::K_PLAIN;
        c    = 8'h00;
        emit = 1'b0;
        if (dec_phase == tekd_pkg::PH_IDLE) begin
            nxt = tekd_pkg::PH_IDLE;
            if (!tick) begin
                if (b == tekd_pkg::BYTE_ESC) begin
                    nxt = tekd_pkg::PH_ESC;
                end else begin
                    emit = 1'b1;
                    c = b;
                end
            end
        end else if (tick) begin
            // timeout in the ctrl-arrow branch drops silently
            if (!(dec_phase inside {tekd_pkg::PH_ONE, tekd_pkg::PH_SEMI,
                                    tekd_pkg::PH_FIVE})) begin
                emit = 1'b1;
                k = tekd_pkg::K_ESC;
            end
        end else begin
            case (dec_phase)
                tekd_pkg::PH_ESC: begin
                    if (b == tekd_pkg::BYTE_LBRACK) nxt = tekd_pkg::PH_CSI;
                    else if (b == tekd_pkg::BYTE_O) nxt = tekd_pkg::PH_SS3;
                    else nxt = tekd_pkg::PH_OTHER;
                end
                tekd_pkg::PH_CSI: begin
                    if (b == tekd_pkg::BYTE_ONE) begin
                        nxt = tekd_pkg::PH_ONE;
                    end else if (b >= tekd_pkg::BYTE_D0 && b <= tekd_pkg::BYTE_D9) begin
                        dec_digit = b;
                        nxt = tekd_pkg::PH_DIGIT;
                    end else begin
                        emit = 1'b1;
                        case (b)
                            tekd_pkg::BYTE_A: k = tekd_pkg::K_UP;
                            tekd_pkg::BYTE_B: k = tekd_pkg::K_DOWN;
                            tekd_pkg::BYTE_C: k = tekd_pkg::K_RIGHT;
                            tekd_pkg::BYTE_D: k = tekd_pkg::K_LEFT;
                            tekd_pkg::BYTE_H: k = tekd_pkg::K_HOME;
                            tekd_pkg::BYTE_F: k = tekd_pkg::K_END;
                            default:          emit = 1'b0;
                        endcase
                    end
                end
                tekd_pkg::PH_SS3: begin
                    if (b == tekd_pkg::BYTE_H) begin
                        emit = 1'b1;
                        k = tekd_pkg::K_HOME;
                    end else if (b == tekd_pkg::BYTE_F) begin
                        emit = 1'b1;
                        k = tekd_pkg::K_END;
                    end
                end
                tekd_pkg::PH_DIGIT: begin
                    if (b == tekd_pkg::BYTE_TILDE) begin
                        emit = 1'b1;
                        case (dec_digit)
                            tekd_pkg::BYTE_D3: k = tekd_pkg::K_DEL;
                            tekd_pkg::BYTE_D5: k = tekd_pkg::K_PGUP;
                            tekd_pkg::BYTE_D6: k = tekd_pkg::K_PGDN;
                            default:           emit = 1'b0;
                        endcase
                    end
                end
                tekd_pkg::PH_ONE: begin
                    if (b == tekd_pkg::BYTE_SEMI) nxt = tekd_pkg::PH_SEMI;
                end
                tekd_pkg::PH_SEMI: begin
                    if (b == tekd_pkg::BYTE_FIVE) nxt = tekd_pkg::PH_FIVE;
                end
                tekd_pkg::PH_FIVE: begin
                    emit = 1'b1;
                    case (b)
                        tekd_pkg::BYTE_A: k = tekd_pkg::K_CUP;
                        tekd_pkg::BYTE_B: k = tekd_pkg::K_CDOWN;
                        tekd_pkg::BYTE_C: k = tekd_pkg::K_CRIGHT;
                        tekd_pkg::BYTE_D: k = tekd_pkg::K_CLEFT;
                        default:          emit = 1'b0;
                    endcase
                end
                default: ;
            endcase
        end
        if (emit) begin
            nxt = tekd_pkg::PH_IDLE;
            key_exp_q.push_back('{key: k, ch: c});
        end
        dec_phase = nxt;
    endfunction

    // sender
    always @(posedge i_clk) begin : drv
        bit       nv;
        t_in_word w;
        nv = 1'b0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                decode_word(i_mode, i_data_byte);
            if (i_in_valid && o_in_stall) begin
                nv = 1'b1;
            end else if (in_gap > 0) begin
                in_gap = in_gap - 1;
            end else if (pend_q.size() > 0 && idle_allowed() && $urandom_range(0, 4) == 0) begin
                in_gap = int'($urandom_range(0, 3));
            end else if (pend_q.size() > 0) begin
                w = pend_q.pop_front();
                nv = 1'b1;
                i_mode <= w.tick;
                i_data_byte <= w.data;
            end
            i_in_valid <= nv;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : mon
        bit        ns;
        t_key_word e;
        ns = 1'b0;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                keys_seen = keys_seen + 1;
                if (key_exp_q.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected word: expected none, actual key %0d char %0d",
                             $time, o_key_code, o_char_value);
                end else begin
                    e = key_exp_q.pop_front();
                    if (o_key_code !== e.key) begin
                        errors = errors + 1;
                        $display("%0t: key_code mismatch: expected %0d, actual %0d",
                                 $time, e.key, o_key_code);
                    end
                    if (o_char_value !== e.ch) begin
                        errors = errors + 1;
                        $display("%0t: char_value mismatch: expected %0d, actual %0d",
                                 $time, e.ch, o_char_value);
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt = hold_cnt - 1;
                ns = 1'b1;
            end else if (!hold_done && keys_seen >= HOLD_AFTER) begin
                // long back-pressure so the block fills and stalls its input
                hold_done = 1'b1;
                hold_cnt = HOLD_CYCLES - 1;
                ns = 1'b1;
            end else if (out_gap > 0) begin
                out_gap = out_gap - 1;
                ns = 1'b1;
            end else if (idle_allowed() && $urandom_range(0, 4) == 0) begin
                out_gap = int'($urandom_range(0, 3));
                ns = 1'b1;
            end
            i_out_stall <= ns;
        end
    end

    function automatic void queue_word(input bit tick, input logic [7:0] data);
        pend_q.push_back('{tick: tick, data: data});
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] any_byte_but_esc();
        logic [7:0] b;
        b = any_byte();
        if (b == tekd_pkg::BYTE_ESC)
            b = ~b;
        return b;
    endfunction

    function automatic logic [7:0] any_digit();
        return 8'(tekd_pkg::BYTE_D0 + $urandom_range(0, 9));
    endfunction

    // bytes that mean something somewhere inside a sequence
    function automatic logic [7:0] seq_byte();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0: b = tekd_pkg::BYTE_LBRACK;
            1: b = tekd_pkg::BYTE_O;
            2: b = tekd_pkg::BYTE_ONE;
            3: b = tekd_pkg::BYTE_SEMI;
            4: b = tekd_pkg::BYTE_FIVE;
            5: b = tekd_pkg::BYTE_TILDE;
            6: b = any_digit();
            7: b = 8'(tekd_pkg::BYTE_A + $urandom_range(0, 3));
            8: b = tekd_pkg::BYTE_H;
            9: b = tekd_pkg::BYTE_F;
            10: b = tekd_pkg::BYTE_ESC;
            default: b = any_byte();
        endcase
        return b;
    endfunction

    initial begin : stim
        int         sel;
        int         kind;
        int         n;
        logic [7:0] d;

        // directed: byte extremes, idle timeout, lone ESC, one of each sequence form
        queue_word(1'b0, 8'h00);
        queue_word(1'b0, 8'hFF);
        queue_word(1'b1, 8'hFF);
        queue_word(1'b0, tekd_pkg::BYTE_ESC);
        queue_word(1'b1, 8'h00);
        queue_word(1'b0, tekd_pkg::BYTE_ESC);
        queue_word(1'b0, tekd_pkg::BYTE_LBRACK);
        queue_word(1'b0, tekd_pkg::BYTE_A);
        queue_word(1'b0, tekd_pkg::BYTE_ESC);
        queue_word(1'b0, tekd_pkg::BYTE_O);
        queue_word(1'b0, tekd_pkg::BYTE_F);
        queue_word(1'b0, tekd_pkg::BYTE_ESC);
        queue_word(1'b0, tekd_pkg::BYTE_LBRACK);
        queue_word(1'b0, tekd_pkg::BYTE_D3);
        queue_word(1'b0, tekd_pkg::BYTE_TILDE);
        queue_word(1'b0, tekd_pkg::BYTE_ESC);
        queue_word(1'b0, tekd_pkg::BYTE_LBRACK);
        queue_word(1'b0, tekd_pkg::BYTE_ONE);
        queue_word(1'b0, tekd_pkg::BYTE_SEMI);
        queue_word(1'b0, tekd_pkg::BYTE_FIVE);
        queue_word(1'b0, tekd_pkg::BYTE_D);
        // ESC + other byte: next byte swallowed, then timeout gives ESC
        queue_word(1'b0, tekd_pkg::BYTE_ESC);
        queue_word(1'b0, 8'h78);
        queue_word(1'b0, 8'h79);
        queue_word(1'b1, 8'h00);

        while (pend_q.size() < N_WORDS) begin
            sel = $urandom_range(0, 99);
            if (sel < 26) begin
                queue_word(1'b0, any_byte_but_esc());
            end else if (sel < 30) begin
                queue_word(1'b1, any_byte());
            end else if (sel < 72) begin
                kind = $urandom_range(0, 14);
                queue_word(1'b0, tekd_pkg::BYTE_ESC);
                if (kind < 6) begin
                    queue_word(1'b0, tekd_pkg::BYTE_LBRACK);
                    if (kind < 4) queue_word(1'b0, 8'(tekd_pkg::BYTE_A + kind));
                    else if (kind == 4) queue_word(1'b0, tekd_pkg::BYTE_H);
                    else queue_word(1'b0, tekd_pkg::BYTE_F);
                end else if (kind < 8) begin
                    queue_word(1'b0, tekd_pkg::BYTE_O);
                    queue_word(1'b0, (kind == 6) ? tekd_pkg::BYTE_H : tekd_pkg::BYTE_F);
                end else if (kind < 11) begin
                    queue_word(1'b0, tekd_pkg::BYTE_LBRACK);
                    if (kind == 8) queue_word(1'b0, tekd_pkg::BYTE_D3);
                    else if (kind == 9) queue_word(1'b0, tekd_pkg::BYTE_D5);
                    else queue_word(1'b0, tekd_pkg::BYTE_D6);
                    queue_word(1'b0, tekd_pkg::BYTE_TILDE);
                end else begin
                    queue_word(1'b0, tekd_pkg::BYTE_LBRACK);
                    queue_word(1'b0, tekd_pkg::BYTE_ONE);
                    queue_word(1'b0, tekd_pkg::BYTE_SEMI);
                    queue_word(1'b0, tekd_pkg::BYTE_FIVE);
                    queue_word(1'b0, 8'(tekd_pkg::BYTE_A + (kind - 11)));
                end
            end else if (sel < 84) begin
                // timeout at each depth of a sequence
                queue_word(1'b0, tekd_pkg::BYTE_ESC);
                case ($urandom_range(0, 6))
                    0: ;
                    1: queue_word(1'b0, tekd_pkg::BYTE_LBRACK);
                    2: queue_word(1'b0, tekd_pkg::BYTE_O);
                    3: begin
                        queue_word(1'b0, tekd_pkg::BYTE_LBRACK);
                        d = any_digit();
                        if (d == tekd_pkg::BYTE_ONE) d = tekd_pkg::BYTE_D9;
                        queue_word(1'b0, d);
                    end
                    4: queue_word(1'b0, any_byte_but_esc());
                    5: begin
                        // ctrl branch: first timeout drops, second yields ESC
                        queue_word(1'b0, tekd_pkg::BYTE_LBRACK);
                        queue_word(1'b0, tekd_pkg::BYTE_ONE);
                        n = $urandom_range(0, 2);
                        if (n > 0) queue_word(1'b0, tekd_pkg::BYTE_SEMI);
                        if (n > 1) queue_word(1'b0, tekd_pkg::BYTE_FIVE);
                        queue_word(1'b1, any_byte());
                    end
                    default: begin
                        queue_word(1'b0, tekd_pkg::BYTE_LBRACK);
                        queue_word(1'b0, any_digit());
                        queue_word(1'b0, tekd_pkg::BYTE_TILDE);
                    end
                endcase
                queue_word(1'b1, any_byte());
            end else begin
                // broken sequence, then a timeout to get back to idle
                queue_word(1'b0, tekd_pkg::BYTE_ESC);
                n = $urandom_range(1, 5);
                repeat (n) queue_word(1'b0, seq_byte());
                queue_word(1'b1, any_byte());
                if ($urandom_range(0, 1) == 0)
                    queue_word(1'b1, any_byte());
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() > 0 || i_in_valid) @(posedge i_clk);
        while (key_exp_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
